/* hw/rtl/kop_pkg.sv */
`timescale 1ns / 1ps
package kop_pkg;

	localparam int CORDIC_ITERS = 31;
	localparam int ITER_W = $clog2(CORDIC_ITERS);

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
	localparam logic [63:0] PI4_Q60 = 64'h0C90FDAA22168C23;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic [47:0] TOL_TURN48 = 48'd44798134;

	// shared multiplier: 64-bit A times 64-bit B, B taken one 16-bit chunk a cycle
	localparam int MUL_CHUNK_W = 16;
	localparam int MUL_CHUNKS = 64 / MUL_CHUNK_W;
	localparam int MUL_CNT_W = $clog2(MUL_CHUNKS);

	// divider: floor(num * 2^30 / den), one quotient bit a cycle
	localparam int DIV_NUM_W = 50;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_STEPS = 80;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [47:0] QUOT_CAP = 48'h8000_0000_0000;

	typedef logic [63:0] atan_tab_t [CORDIC_ITERS];

	// arctangent table, Q60 radians, truncated series
	function automatic atan_tab_t atan_build();
		atan_tab_t tab;
		int unsigned sh;
		logic [63:0] term;
		logic [63:0] sum;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (i == 0) begin
				tab[i] = PI4_Q60;
			end else begin
				sum = '0;
				for (int k = 0; k < 32; k++) begin
					sh = i * (2 * k + 1);
					if (sh <= 60) begin
						term = (64'd1 << (60 - sh)) / 64'(2 * k + 1);
						if ((k & 1) != 0) begin
							sum = sum - term;
						end else begin
							sum = sum + term;
						end
					end
				end
				tab[i] = sum;
			end
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = atan_build();

endpackage

/* hw/rtl/kop_mul.sv */
`timescale 1ns / 1ps
module kop_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	localparam int CW = kop_pkg::MUL_CHUNK_W;

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [kop_pkg::MUL_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [63+CW:0] pp;

	assign pp = {{CW{1'b0}}, a_q} * {64'b0, b_q[63 -: CW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kop_pkg::MUL_CNT_W'(kop_pkg::MUL_CHUNKS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// most significant chunk first: acc = acc * 2^16 + A * chunk
	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << CW) + 128'(pp);
			b_q   <= b_q << CW;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* hw/rtl/kop_div.sv */
`timescale 1ns / 1ps
module kop_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [kop_pkg::DIV_NUM_W-1:0]  num,
	input  logic [kop_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [47:0]                    quot
);

	localparam int NW = kop_pkg::DIV_NUM_W;
	localparam int DW = kop_pkg::DIV_DEN_W;
	localparam int SW = kop_pkg::DIV_STEPS;

	logic [SW-1:0] sh_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [47:0]   q_q;
	logic          sat_q;
	logic [kop_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DW:0] rem_sh;
	logic        ge;
	logic [DW:0] rem_sub;
	logic [48:0] q_nx;

	assign rem_sh  = {rem_q, sh_q[SW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign q_nx    = {q_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kop_pkg::DIV_CNT_W'(SW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// once the running quotient passes the cap it stays at the cap
	always_ff @(posedge clk) begin
		if (go) begin
			sh_q  <= {num, {(SW - NW){1'b0}}};
			rem_q <= '0;
			den_q <= den;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			sh_q  <= sh_q << 1;
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			q_q   <= q_nx[47:0];
			sat_q <= sat_q | (q_nx > {1'b0, kop_pkg::QUOT_CAP});
		end
	end

	assign done = done_q;
	assign quot = sat_q ? kop_pkg::QUOT_CAP : q_q;

endmodule

/* hw/rtl/kepler_orbit_propagator.sv */
`timescale 1ns / 1ps
// When not orbiting, an accepted item goes straight to S_DONE. When orbiting it takes
// k Newton steps (1..MAX_NEWTON_STEPS); each step is one CORDIC pass (angle scaling,
// 31 rotations), three products on the shared 64x64 multiplier and a divide. A result
// still waiting at the output holds the next one back in S_DONE.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
// is registered. Reset: asynchronous, active low; configuration registers, mean anomaly and position clear.
module kepler_orbit_propagator #(
	parameter int MAX_NEWTON_STEPS = 16,
	parameter int ANGLE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        time_step,
	input  logic signed [47:0] parent_x,
	input  logic signed [47:0] parent_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] body_x,
	output logic signed [47:0] body_y,
	output logic               not_converged,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	localparam int KW = $clog2(MAX_NEWTON_STEPS);

	typedef enum logic [1:0] {
		REG_ORBITING,
		REG_MEAN_MOTION,
		REG_SEMI_MAJOR,
		REG_ECCENTRICITY
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ADV, S_CZ, S_ROT, S_ES, S_ESI, S_EC, S_DIV,
		S_XA, S_EE, S_SQRT, S_SR, S_YA, S_DONE
	} state_t;

	state_t state_q;

	logic        orbiting_q;
	logic [47:0] mm_q;
	logic [39:0] sma_q;
	logic [15:0] ecc_q;

	logic [ANGLE_BITS-1:0] ma_q;
	logic signed [47:0] body_x_q, body_y_q;
	logic nc_q, nc_out_q, out_valid_q, mpend_q, dpend_q;

	// datapath
	logic [31:0] ts_q;
	logic signed [47:0] px_q, py_q;
	logic [47:0] ang_q;
	logic [1:0]  quad_q;
	logic signed [33:0] x_q, y_q, c_q, s_q;
	logic signed [63:0] z_q;
	logic [kop_pkg::ITER_W-1:0] i_q;
	logic [KW-1:0] k_q;
	logic [47:0] d_q, p1_q, sr_q;
	logic signed [49:0] f_q, xr_q, yr_q;
	logic [31:0] g_q;
	logic [32:0] v_q, bit_q;
	logic [33:0] res_q;
	logic fin_q;

	// shared units
	logic mul_go, mul_done, use_mul;
	logic [63:0] mul_a, mul_b;
	logic [127:0] prod;
	logic div_go, div_done;
	logic [47:0] quot;
	logic [49:0] f_n, f_mag;

	kop_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod)
	);

	kop_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(f_mag), .den(g_q),
		.done(div_done), .quot(quot)
	);

	// angle reduction
	logic [47:0] m48, ang_h, r48, r_mag;
	logic [1:0]  quad;
	logic        r_neg;
	logic [ANGLE_BITS-1:0] ma_nx;

	assign ma_nx = ma_q + prod[56-ANGLE_BITS +: ANGLE_BITS];
	assign m48   = 48'(ma_q) << (48 - ANGLE_BITS);
	assign ang_h = ang_q + 48'h2000_0000_0000;
	assign quad  = ang_h[47:46];
	assign r48   = ang_q - {quad, 46'b0};
	assign r_neg = r48[47];
	assign r_mag = r_neg ? -r48 : r48;

	// one CORDIC rotation
	logic signed [33:0] dx, dy, x_n, y_n, c_n, s_n;
	logic signed [63:0] z_n, atan_v;
	logic z_pos;

	assign dx     = y_q >>> i_q;
	assign dy     = x_q >>> i_q;
	assign atan_v = $signed(kop_pkg::ATAN_TAB[i_q]);
	assign z_pos  = !z_q[63];
	assign x_n    = z_pos ? x_q - dx : x_q + dx;
	assign y_n    = z_pos ? y_q + dy : y_q - dy;
	assign z_n    = z_pos ? z_q - atan_v : z_q + atan_v;

	always_comb begin
		unique case (quad_q)
			2'd0: begin c_n = x_n;  s_n = y_n;  end
			2'd1: begin c_n = -y_n; s_n = x_n;  end
			2'd2: begin c_n = -x_n; s_n = -y_n; end
			default: begin c_n = y_n; s_n = -x_n; end
		endcase
	end

	// Newton step terms
	logic [33:0] s_mag, c_mag;
	logic s_neg, c_neg;
	logic signed [33:0] sarv, g34;
	logic [47:0] p2, d_n;
	logic conv, last_k;

	assign s_neg = s_q[33];
	assign c_neg = c_q[33];
	assign s_mag = s_neg ? 34'(-s_q) : 34'(s_q);
	assign c_mag = c_neg ? 34'(-c_q) : 34'(c_q);
	assign f_n   = {{2{d_q[47]}}, d_q} + (s_neg ? 50'(prod[109:62]) : -50'(prod[109:62]));
	assign f_mag = f_q[49] ? 50'(-f_q) : 50'(f_q);
	assign p2    = prod[47:0];
	assign sarv  = c_neg ? -$signed(34'((p2 + 48'hFFFF) >> 16)) : $signed(34'(p2 >> 16));
	assign g34   = $signed(34'h0_4000_0000) - sarv;
	assign d_n   = f_q[49] ? d_q + quot : d_q - quot;
	assign conv  = quot < kop_pkg::TOL_TURN48;
	assign last_k = k_q == KW'(MAX_NEWTON_STEPS - 1);

	// position terms
	logic signed [34:0] cm;
	logic [34:0] cm_mag;
	logic [33:0] sq_try;
	logic signed [50:0] sx, sy;
	logic signed [47:0] bx_n, by_n;

	assign cm     = $signed({c_q[33], c_q}) - $signed({5'b0, ecc_q, 14'b0});
	assign cm_mag = cm[34] ? 35'(-cm) : 35'(cm);
	assign sq_try = res_q + 34'(bit_q);
	assign sx     = 51'(xr_q) + 51'(px_q);
	assign sy     = 51'(yr_q) + 51'(py_q);

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		logic signed [50:0] hi, lo;
		hi = 51'sh0_7FFF_FFFF_FFFF;
		lo = -51'sh0_8000_0000_0000;
		if (v > hi) begin
			return hi[47:0];
		end else if (v < lo) begin
			return lo[47:0];
		end
		return v[47:0];
	endfunction

	assign bx_n = sat48(sx);
	assign by_n = sat48(sy);

	always_comb begin
		use_mul = 1'b1;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_ADV: begin mul_a = 64'(mm_q); mul_b = 64'(ts_q); end
			S_CZ:  begin mul_a = kop_pkg::PI_Q62; mul_b = 64'(r_mag); end
			S_ES:  begin mul_a = 64'(ecc_q); mul_b = 64'(s_mag); end
			S_ESI: begin mul_a = kop_pkg::INV2PI_Q64; mul_b = 64'(p1_q); end
			S_EC:  begin mul_a = 64'(ecc_q); mul_b = 64'(c_mag); end
			S_XA:  begin mul_a = 64'(sma_q); mul_b = 64'(cm_mag); end
			S_EE:  begin mul_a = 64'(ecc_q); mul_b = 64'(ecc_q); end
			S_SR:  begin mul_a = 64'(res_q); mul_b = 64'(s_mag); end
			S_YA:  begin mul_a = 64'(sma_q); mul_b = 64'(sr_q); end
			default: use_mul = 1'b0;
		endcase
	end

	assign mul_go = use_mul && !mpend_q;
	assign div_go = (state_q == S_DIV) && !dpend_q;
	logic mul_ret;
	assign mul_ret = mpend_q && mul_done;

	assign in_ready = state_q == S_IDLE;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbiting_q <= 1'b0;
			mm_q       <= '0;
			sma_q      <= '0;
			ecc_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORBITING:     orbiting_q <= cfg_data[0];
				REG_MEAN_MOTION:  mm_q       <= cfg_data;
				REG_SEMI_MAJOR:   sma_q      <= cfg_data[39:0];
				REG_ECCENTRICITY: ecc_q      <= cfg_data[15:0];
			endcase
		end
	end

	// sequencer, kept state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ma_q        <= '0;
			body_x_q    <= '0;
			body_y_q    <= '0;
			nc_q        <= 1'b0;
			nc_out_q    <= 1'b0;
			out_valid_q <= 1'b0;
			mpend_q     <= 1'b0;
			dpend_q     <= 1'b0;
		end else begin
			// S_DONE reloads the output itself
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (mul_go) begin
				mpend_q <= 1'b1;
			end else if (mul_ret) begin
				mpend_q <= 1'b0;
			end
			if (div_go) begin
				dpend_q <= 1'b1;
			end else if (dpend_q && div_done) begin
				dpend_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						nc_q    <= 1'b0;
						state_q <= orbiting_q ? S_ADV : S_DONE;
					end
				end
				S_ADV: begin
					if (mul_ret) begin
						ma_q    <= ma_nx;
						state_q <= S_CZ;
					end
				end
				S_CZ:  if (mul_ret) state_q <= S_ROT;
				S_ROT: begin
					if (i_q == kop_pkg::ITER_W'(kop_pkg::CORDIC_ITERS - 1)) begin
						state_q <= fin_q ? S_XA : S_ES;
					end
				end
				S_ES:  if (mul_ret) state_q <= S_ESI;
				S_ESI: if (mul_ret) state_q <= S_EC;
				S_EC:  if (mul_ret) state_q <= S_DIV;
				S_DIV: begin
					if (dpend_q && div_done) begin
						if (!conv && last_k) begin
							nc_q <= 1'b1;
						end
						state_q <= S_CZ;
					end
				end
				S_XA:  if (mul_ret) state_q <= S_EE;
				S_EE:  if (mul_ret) state_q <= S_SQRT;
				S_SQRT: if (bit_q == 33'd1) state_q <= S_SR;
				S_SR:  if (mul_ret) state_q <= S_YA;
				S_YA:  if (mul_ret) state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						if (orbiting_q) begin
							body_x_q <= bx_n;
							body_y_q <= by_n;
						end
						nc_out_q    <= nc_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ts_q <= time_step;
					px_q <= parent_x;
					py_q <= parent_y;
				end
			end
			S_ADV: begin
				if (mul_ret) begin
					ang_q <= 48'(ma_nx) << (48 - ANGLE_BITS);
					d_q   <= '0;
					k_q   <= '0;
					fin_q <= 1'b0;
				end
			end
			S_CZ: begin
				if (mul_ret) begin
					quad_q <= quad;
					z_q    <= r_neg ? -$signed(prod[112:49]) : $signed(prod[112:49]);
					x_q    <= kop_pkg::CORDIC_GAIN;
					y_q    <= '0;
					i_q    <= '0;
				end
			end
			S_ROT: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				i_q <= i_q + 1'b1;
				if (i_q == kop_pkg::ITER_W'(kop_pkg::CORDIC_ITERS - 1)) begin
					c_q <= c_n;
					s_q <= s_n;
				end
			end
			S_ES:  if (mul_ret) p1_q <= prod[47:0];
			S_ESI: if (mul_ret) f_q <= f_n;
			S_EC:  if (mul_ret) g_q <= (g34 < 34'sd1) ? 32'd1 : g34[31:0];
			S_DIV: begin
				if (dpend_q && div_done) begin
					d_q   <= d_n;
					k_q   <= k_q + 1'b1;
					ang_q <= m48 + d_n;
					if (conv || last_k) begin
						fin_q <= 1'b1;
					end
				end
			end
			S_XA: begin
				if (mul_ret) begin
					xr_q <= cm[34] ? -$signed(prod[79:30]) : $signed(prod[79:30]);
				end
			end
			S_EE: begin
				if (mul_ret) begin
					v_q   <= 33'h1_0000_0000 - prod[32:0];
					res_q <= '0;
					bit_q <= 33'h1_0000_0000;
				end
			end
			S_SQRT: begin
				if ({1'b0, v_q} >= sq_try) begin
					v_q   <= v_q - sq_try[32:0];
					res_q <= (res_q >> 1) + 34'(bit_q);
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_SR: if (mul_ret) sr_q <= prod[47:0];
			S_YA: begin
				if (mul_ret) begin
					yr_q <= s_neg ? -$signed(prod[95:46]) : $signed(prod[95:46]);
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign body_x        = body_x_q;
	assign body_y        = body_y_q;
	assign not_converged = nc_out_q;

endmodule
